@@ rtl/core/sitda_pkg.sv @@
// package for the signed integer to decimal ascii formatter
// holds widths, character codes, sequencer state codes and shared types
// no dependencies
`default_nettype none

package sitda_pkg;

    // width of the input integer
    localparam int INPUT_BITS = 32;

    // decimal digits needed for the largest magnitude 2^(INPUT_BITS-1)
    localparam int NDIG = ((INPUT_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;

    localparam int CNT_W  = $clog2(INPUT_BITS);
    localparam int DCNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    // sequencer states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_IDLE = 2'd0;
    localparam logic [ST_W-1:0] S_CONV = 2'd1;
    localparam logic [ST_W-1:0] S_SIGN = 2'd2;
    localparam logic [ST_W-1:0] S_DIG  = 2'd3;

    typedef logic [INPUT_BITS-1:0] t_mag;
    typedef logic [BCD_W-1:0]      t_bcd;
    typedef logic [CHAR_W-1:0]     t_char;

endpackage

`default_nettype wire

@@ rtl/core/sitda_in_if.sv @@
// input channel of the formatter: one signed integer per transaction
// depends on sitda_pkg
`default_nettype none

interface sitda_in_if;
    import sitda_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [INPUT_BITS-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sitda_out_if.sv @@
// output channel of the formatter: one ascii character per transaction
// depends on sitda_pkg
`default_nettype none

interface sitda_out_if;
    import sitda_pkg::*;

    logic   valid;
    logic   ready;
    t_char  char_code;
    logic   last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sitda_dabble_step.sv @@
// one shift-and-add-3 binary to bcd step, shared over all conversion cycles
// depends on sitda_pkg
`default_nettype none

module sitda_dabble_step (
    input  wire sitda_pkg::t_bcd i_bcd,
    input  wire                  i_bit,
    output sitda_pkg::t_bcd      o_bcd
);
    import sitda_pkg::*;

    t_bcd adj;

    // digits at five or more get three added before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (i_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = i_bcd[d*4 +: 4];
            end
        end
    end

    assign o_bcd = {adj[BCD_W-2:0], i_bit};

endmodule

`default_nettype wire

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// top level of the signed integer to decimal ascii formatter
// depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_dabble_step
//
//  channel  dir  payload               per transaction
//  i_src    in   value [INPUT_BITS]    one signed integer
//  o_res    out  char_code [6], last   one ascii character
//
// one integer is loaded as its magnitude, takes INPUT_BITS dabble steps through the shared
// step unit, then puts out the sign if negative and then goes through every bcd
// digit slot (leading zeros skipped one per cycle, digits emitted)
// i_src.ready is high only between integers
// a stalled o_res holds the character; the sequencer waits only where it would emit the next one
// reset is synchronous and active low and clears the sequencer and o_res.valid
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sitda_in_if.sink    i_src,
    sitda_out_if.source o_res
);
    import sitda_pkg::*;

    localparam t_mag MAG_ONE = {{(INPUT_BITS-1){1'b0}}, 1'b1};

    logic [ST_W-1:0]   r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic              r_neg, n_neg;
    logic              r_seen, n_seen;
    t_mag              r_bin, n_bin;
    t_bcd              r_bcd, n_bcd;
    logic              r_out_valid, n_out_valid;
    t_char             r_char, n_char;
    logic              r_last, n_last;

    t_bcd       step_bcd;
    t_mag       in_raw;
    logic [3:0] top_dig;
    logic       slot_free;
    logic       accept;

    sitda_dabble_step u_step (
        .i_bcd (r_bcd),
        .i_bit (r_bin[INPUT_BITS-1]),
        .o_bcd (step_bcd)
    );

    assign in_raw    = t_mag'(i_src.value);
    assign top_dig   = r_bcd[BCD_W-1 -: 4];
    assign slot_free = !r_out_valid || o_res.ready;
    assign accept    = i_src.valid && i_src.ready;

    assign i_src.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.char_code = r_char;
    assign o_res.last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_res.ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = in_raw[INPUT_BITS-1];
                    n_bin   = in_raw[INPUT_BITS-1] ? (~in_raw + MAG_ONE) : in_raw;
                    n_bcd   = '0;
                    n_seen  = 1'b0;
                    n_cnt   = CNT_W'(INPUT_BITS - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = step_bcd;
                n_bin = {r_bin[INPUT_BITS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_dcnt  = DCNT_W'(NDIG - 1);
                    n_state = r_neg ? S_SIGN : S_DIG;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIG;
                end
            end
            S_DIG: begin
                // leading zeros drop out without a transaction, the ones digit always goes
                if (!r_seen && top_dig == 4'd0 && r_dcnt != '0) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dcnt = r_dcnt - 1'b1;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO + {2'b00, top_dig};
                    n_last      = (r_dcnt == '0);
                    n_seen      = 1'b1;
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    if (r_dcnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dcnt = r_dcnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_seen      <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_dcnt      <= n_dcnt;
            r_seen      <= n_seen;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

@@ rtl/core/sitda_checker.sv @@
// port-level checker for the decimal ascii formatter, bound to the top level
// depends on sitda_pkg and signed_int_to_decimal_ascii
`default_nettype none

module sitda_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   i_in_ready,
    input wire                   i_out_valid,
    input wire                   i_out_ready,
    input wire sitda_pkg::t_char i_char,
    input wire                   i_last
);
    import sitda_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char) && $stable(i_last))
        else $error("stalled character changed or dropped");

    // only the minus sign or a decimal digit goes out
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_char == CH_MINUS) ||
                        (i_char >= CH_ZERO && i_char <= CH_ZERO + 6'd9))
        else $error("illegal character code");

    // the sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char == CH_MINUS |-> !i_last)
        else $error("minus sign flagged last");

    // the formatter is busy right after taking an integer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an input transaction");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_src.valid),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_char      (o_res.char_code),
    .i_last      (o_res.last)
);

`default_nettype wire
